// ===== rtl/bptc_pkg.sv =====
// shared types and constants of the barometric compensation block
package bptc_pkg;

    // one input word: raw temperature and raw pressure samples
    typedef struct packed {
        logic [23:0] raw_temperature;
        logic [23:0] raw_pressure;
    } t_in_word;

    // one output word: compensated temperature, pressure and clamp flag
    typedef struct packed {
        logic signed [15:0] temperature_out;
        logic [23:0]        pressure_out;
        logic               saturated;
    } t_out_word;

    // unpacked calibration coefficients
    typedef struct packed {
        logic [15:0]        t1;
        logic [15:0]        t2;
        logic signed [7:0]  t3;
        logic signed [15:0] p1;
        logic signed [15:0] p2;
        logic signed [7:0]  p3;
        logic signed [7:0]  p4;
        logic [15:0]        p5;
        logic [15:0]        p6;
        logic signed [7:0]  p7;
        logic signed [7:0]  p8;
        logic signed [15:0] p9;
        logic signed [7:0]  p10;
        logic signed [7:0]  p11;
    } t_coef;

    // rounded and clamped temperature travelling beside the pressure path
    typedef struct packed {
        logic signed [15:0] temp;
        logic               sat;
    } t_temp_res;

    // configuration register indexes
    typedef enum logic [1:0] {
        CFG_TEMP_COEFF   = 2'd0,
        CFG_PRESS_SENS   = 2'd1,
        CFG_PRESS_OFFSET = 2'd2,
        CFG_PRESS_SQUARE = 2'd3
    } t_cfg_idx;

    localparam int CFG_DATA_W = 48;
    localparam int SAMPLE_W   = 24;

    // datapath widths (linearized temperature over 2^48, horner terms)
    localparam int TN_W   = 60;
    localparam int A3_W   = 33;
    localparam int A2_W   = 33;
    localparam int A1_W   = 61;
    localparam int A0_W   = 87;
    localparam int H2_W   = 93;
    localparam int H1_W   = 153;
    localparam int H0_W   = 213;
    localparam int P_SHIFT = 175;
    localparam int MAC_B_W = 64;

    localparam int LAT_FRONT  = 4;
    localparam int LAT_MAC    = 6;
    localparam int PIPE_DEPTH = 1 + LAT_FRONT + 3 * LAT_MAC + 1;

endpackage

// ===== rtl/bptc_temp.sv =====
// linearized temperature front end: tn = d*t2*2^18 + d^2*t3
module bptc_temp (
    input  logic                                i_clk,
    input  logic                                i_en,
    input  logic [bptc_pkg::SAMPLE_W-1:0]       i_rt,
    input  bptc_pkg::t_coef                     i_coef,
    output logic signed [bptc_pkg::TN_W-1:0]    o_tn
);
    import bptc_pkg::*;

    logic signed [24:0] n_d,  r_d;
    logic signed [41:0] n_m1, r_m1, r_m1b;
    logic signed [49:0] n_m2, r_m2;
    logic signed [57:0] n_m3, r_m3;
    logic signed [TN_W-1:0] n_tn, r_tn;
    logic signed [16:0] t2s;
    logic signed [7:0]  t3s;
    logic signed [TN_W-1:0] tn_hi, tn_lo;

    assign t2s = {1'b0, i_coef.t2};
    assign t3s = i_coef.t3;

    assign n_d   = {1'b0, i_rt} - {1'b0, i_coef.t1, 8'd0};
    assign n_m1  = r_d * t2s;
    assign n_m2  = r_d * r_d;
    assign n_m3  = r_m2 * t3s;
    assign tn_hi = {r_m1b, 18'd0};
    assign tn_lo = {{(TN_W-58){r_m3[57]}}, r_m3};
    assign n_tn  = tn_hi + tn_lo;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_d   <= n_d;
            r_m1  <= n_m1;
            r_m2  <= n_m2;
            r_m1b <= r_m1;
            r_m3  <= n_m3;
            r_tn  <= n_tn;
        end
    end

    assign o_tn = r_tn;

endmodule

// ===== rtl/bptc_coef.sv =====
// pressure-only horner coefficients a3..a0 from the raw pressure
module bptc_coef (
    input  logic                                i_clk,
    input  logic                                i_en,
    input  logic [bptc_pkg::SAMPLE_W-1:0]       i_p,
    input  bptc_pkg::t_coef                     i_coef,
    output logic signed [bptc_pkg::A3_W-1:0]    o_a3,
    output logic signed [bptc_pkg::A2_W-1:0]    o_a2,
    output logic signed [bptc_pkg::A1_W-1:0]    o_a1,
    output logic signed [bptc_pkg::A0_W-1:0]    o_a0
);
    import bptc_pkg::*;

    // rounding half of the final shift, pre-scaled into a0
    localparam logic [A0_W-1:0] A0_ROUND = {{(A0_W-59){1'b0}}, 1'b1, 58'd0};

    logic signed [24:0] ps;
    logic signed [16:0] p1m, p2m;
    logic signed [7:0]  p3s, p4s, p7s, p8s, p10s, p11s;
    logic signed [15:0] p9s;

    // first stage
    logic [23:0]        r_p;
    logic [47:0]        r_p2;
    logic signed [32:0] r_a3p, r_a2p;
    logic signed [41:0] r_a1p, r_a0p;
    // second stage
    logic [71:0]        r_p3;
    logic signed [64:0] r_q9;
    logic signed [56:0] r_q10;
    logic signed [32:0] r_a3p2, r_a2p2;
    logic signed [41:0] r_a1p2, r_a0p2;
    logic signed [48:0] p2s;
    logic signed [72:0] p3s_w;
    logic signed [64:0] n_q9;
    logic signed [56:0] n_q10;
    // third and fourth stages
    logic [A3_W-1:0]    r_a3, r_a3b;
    logic [A2_W-1:0]    r_a2, r_a2b;
    logic [A1_W-1:0]    r_a1, r_a1b;
    logic [A0_W-1:0]    r_a0p3, r_a0;
    logic signed [80:0] r_r11, n_r11;
    logic signed [32:0] n_a3p, n_a2p;
    logic signed [41:0] n_a1p, n_a0p;

    assign ps   = {1'b0, i_p};
    assign p1m  = {i_coef.p1[15], i_coef.p1} - 17'sd16384;
    assign p2m  = {i_coef.p2[15], i_coef.p2} - 17'sd16384;
    assign p3s  = i_coef.p3;
    assign p4s  = i_coef.p4;
    assign p7s  = i_coef.p7;
    assign p8s  = i_coef.p8;
    assign p9s  = i_coef.p9;
    assign p10s = i_coef.p10;
    assign p11s = i_coef.p11;

    assign n_a3p = p4s * ps;
    assign n_a2p = p3s * ps;
    assign n_a1p = p2m * ps;
    assign n_a0p = p1m * ps;

    assign p2s   = {1'b0, r_p2};
    assign n_q9  = p9s * p2s;
    assign n_q10 = p10s * p2s;

    assign p3s_w = {1'b0, r_p3};
    assign n_r11 = p11s * p3s_w;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p    <= i_p;
            r_p2   <= i_p * i_p;
            r_a3p  <= n_a3p;
            r_a2p  <= n_a2p;
            r_a1p  <= n_a1p;
            r_a0p  <= n_a0p;

            r_p3   <= r_p2 * r_p;
            r_q9   <= n_q9;
            r_q10  <= n_q10;
            r_a3p2 <= r_a3p;
            r_a2p2 <= r_a2p;
            r_a1p2 <= r_a1p;
            r_a0p2 <= r_a0p;

            r_a3   <= {{3{p8s[7]}}, p8s, 22'd0} + r_a3p2;
            r_a2   <= {p7s[7], p7s, 24'd0} + r_a2p2;
            r_a1   <= {3'b000, i_coef.p6, 42'd0} + {r_a1p2, 19'd0}
                    + {{4{r_q10[56]}}, r_q10};
            r_a0p3 <= {3'b000, i_coef.p5, 68'd0} + {r_a0p2, 45'd0}
                    + {{5{r_q9[64]}}, r_q9, 17'd0};
            r_r11  <= n_r11;

            r_a3b  <= r_a3;
            r_a2b  <= r_a2;
            r_a1b  <= r_a1;
            r_a0   <= r_a0p3 + {{6{r_r11[80]}}, r_r11} + A0_ROUND;
        end
    end

    assign o_a3 = r_a3b;
    assign o_a2 = r_a2b;
    assign o_a1 = r_a1b;
    assign o_a0 = r_a0;

endmodule

// ===== rtl/bptc_mac.sv =====
// pipelined exact signed multiply-add y = a * b + c over 32-bit limbs
module bptc_mac #(
    parameter int A_W = 33,
    parameter int O_W = 93
) (
    input  logic                                i_clk,
    input  logic                                i_en,
    input  logic signed [A_W-1:0]               i_a,
    input  logic signed [bptc_pkg::TN_W-1:0]    i_b,
    input  logic signed [O_W-1:0]               i_c,
    output logic signed [O_W-1:0]               o_y
);
    import bptc_pkg::*;

    localparam int MAG_W = ((A_W + 32) / 32) * 32;
    localparam int NA    = MAG_W / 32;
    localparam int SUM_W = MAG_W + MAC_B_W;
    localparam int ACC_W = (SUM_W > O_W) ? SUM_W : O_W;
    localparam int NDLY  = LAT_MAC - 1;

    logic [MAG_W-1:0]   a_ext, n_am, r_am;
    logic [MAC_B_W-1:0] b_ext, n_bm, r_bm;
    logic [63:0]        r_pp  [NA][2];
    logic [95:0]        r_row [NA];
    logic [ACC_W-1:0]   v     [3];
    logic [ACC_W-1:0]   r_s01, r_v2, r_sum;
    logic               r_neg [NDLY];
    logic [O_W-1:0]     r_c   [NDLY];
    logic [O_W-1:0]     r_y;

    assign a_ext = {{(MAG_W-A_W){i_a[A_W-1]}}, i_a};
    assign b_ext = {{(MAC_B_W-TN_W){i_b[TN_W-1]}}, i_b};
    assign n_am  = a_ext[MAG_W-1] ? (~a_ext + 1'b1) : a_ext;
    assign n_bm  = b_ext[MAC_B_W-1] ? (~b_ext + 1'b1) : b_ext;

    // rows three limbs wide never overlap when spaced three limbs apart
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            v[k] = '0;
        end
        for (int i = 0; i < NA; i++) begin
            v[i % 3] = v[i % 3] | (ACC_W'(r_row[i]) << (32 * i));
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_am     <= n_am;
            r_bm     <= n_bm;
            r_neg[0] <= i_a[A_W-1] ^ i_b[TN_W-1];
            r_c[0]   <= i_c;
            for (int d = 1; d < NDLY; d++) begin
                r_neg[d] <= r_neg[d-1];
                r_c[d]   <= r_c[d-1];
            end
            for (int i = 0; i < NA; i++) begin
                for (int j = 0; j < 2; j++) begin
                    r_pp[i][j] <= r_am[32*i +: 32] * r_bm[32*j +: 32];
                end
                r_row[i] <= {32'd0, r_pp[i][0]} + {r_pp[i][1], 32'd0};
            end
            r_s01 <= v[0] + v[1];
            r_v2  <= v[2];
            r_sum <= r_s01 + r_v2;
            r_y   <= r_c[NDLY-1] + (r_sum[O_W-1:0] ^ {O_W{r_neg[NDLY-1]}})
                   + {{(O_W-1){1'b0}}, r_neg[NDLY-1]};
        end
    end

    assign o_y = r_y;

endmodule

// ===== rtl/baro_temp_pressure_compensation_top.sv =====
// top level of the barometric temperature and pressure compensation block
// compensates one raw temperature / raw pressure word per clock while the
// output is not held, fully pipelined: a new word is taken every cycle
// unless the pipe is frozen; 24 register stages in all (one input
// register, a four-stage front end for the linearized temperature
// and the pressure-only coefficients, three chained six-stage multiply-add
// units that evaluate the pressure polynomial in horner form over the
// linearized temperature, and one output register). all arithmetic is
// exact integer math; the temperature comes out rounded to nearest in
// 1/256 degC and clamped to 16 bits signed, the pressure rounded to
// nearest in 1/64 Pa and clamped to 0..2^24-1, with saturated set if
// either was clamped. when the output word is held by o_valid with i_stall
// high the whole pipe freezes and o_stall goes high. the four calibration
// registers are written through the plain write port and should only
// change while no word is in flight
module baro_temp_pressure_compensation_top #(
    parameter int ADC_BITS = 24
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // input word channel
    input  logic                                i_valid,
    output logic                                o_stall,
    input  bptc_pkg::t_in_word                  i_in_word,
    // output word channel
    output logic                                o_valid,
    input  logic                                i_stall,
    output bptc_pkg::t_out_word                 o_out_word,
    // calibration write port
    input  logic                                i_cfg_we,
    input  bptc_pkg::t_cfg_idx                  i_cfg_idx,
    input  logic [bptc_pkg::CFG_DATA_W-1:0]     i_cfg_data
);
    import bptc_pkg::*;

    // only the low ADC_BITS bits of a sample are significant
    localparam logic [SAMPLE_W-1:0] ADC_MASK =
        SAMPLE_W'((64'd1 << ADC_BITS) - 64'd1);
    localparam logic signed [TN_W-1:0] T_ROUND = TN_W'(64'd1 << 39);
    localparam int NT = 2 * LAT_MAC;
    localparam int NR = 3 * LAT_MAC;

    // calibration registers
    logic [39:0] r_temp_coeff;
    logic [47:0] r_press_sens;
    logic [47:0] r_press_offset;
    logic [31:0] r_press_square;
    t_coef       coef;

    // pipe control: valid bits ride with the data, one global advance
    logic                  en;
    logic [PIPE_DEPTH-1:0] r_vld;

    logic [SAMPLE_W-1:0] r_rt, r_rp;

    logic signed [TN_W-1:0] tn;
    logic signed [A3_W-1:0] a3;
    logic signed [A2_W-1:0] a2;
    logic signed [A1_W-1:0] a1;
    logic signed [A0_W-1:0] a0;
    logic signed [H2_W-1:0] h2, c2;
    logic signed [H1_W-1:0] h1, c1;
    logic signed [H0_W-1:0] h0, c0;

    // side paths matched to the multiply-add latency
    logic [TN_W-1:0] r_tn_dly [NT];
    logic [A1_W-1:0] r_a1_dly [LAT_MAC];
    logic [A0_W-1:0] r_a0_dly [NT];
    t_temp_res       r_tres_dly [NR];

    logic [TN_W-1:0]       t_sum;
    logic signed [19:0]    tq;
    t_temp_res             n_tres;
    logic signed [H0_W-P_SHIFT-1:0] pq;
    t_out_word             n_out, r_out;

    // coefficient unpacking, bytes little-endian within each register
    assign coef.t1  = r_temp_coeff[15:0];
    assign coef.t2  = r_temp_coeff[31:16];
    assign coef.t3  = r_temp_coeff[39:32];
    assign coef.p1  = r_press_sens[15:0];
    assign coef.p2  = r_press_sens[31:16];
    assign coef.p3  = r_press_sens[39:32];
    assign coef.p4  = r_press_sens[47:40];
    assign coef.p5  = r_press_offset[15:0];
    assign coef.p6  = r_press_offset[31:16];
    assign coef.p7  = r_press_offset[39:32];
    assign coef.p8  = r_press_offset[47:40];
    assign coef.p9  = r_press_square[15:0];
    assign coef.p10 = r_press_square[23:16];
    assign coef.p11 = r_press_square[31:24];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_temp_coeff   <= '0;
            r_press_sens   <= '0;
            r_press_offset <= '0;
            r_press_square <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_TEMP_COEFF:   r_temp_coeff   <= i_cfg_data[39:0];
                CFG_PRESS_SENS:   r_press_sens   <= i_cfg_data[47:0];
                CFG_PRESS_OFFSET: r_press_offset <= i_cfg_data[47:0];
                CFG_PRESS_SQUARE: r_press_square <= i_cfg_data[31:0];
                default: begin
                end
            endcase
        end
    end

    // the pipe holds only while a finished word waits at the output
    assign en      = !(r_vld[PIPE_DEPTH-1] && i_stall);
    assign o_stall = r_vld[PIPE_DEPTH-1] && i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[PIPE_DEPTH-2:0], i_valid};
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_rt <= i_in_word.raw_temperature & ADC_MASK;
            r_rp <= i_in_word.raw_pressure & ADC_MASK;
        end
    end

    // linearized temperature, scaled by 2^48
    bptc_temp u_temp (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_rt   (r_rt),
        .i_coef (coef),
        .o_tn   (tn)
    );

    // pressure-only coefficients of each power of tn
    bptc_coef u_coef (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_p    (r_rp),
        .i_coef (coef),
        .o_a3   (a3),
        .o_a2   (a2),
        .o_a1   (a1),
        .o_a0   (a0)
    );

    // horner: h2 = a3*tn + a2*2^53, h1 = h2*tn + a1*2^85,
    // h0 = h1*tn + a0*2^116 (a0 already carries the rounding half)
    assign c2 = {{(H2_W-A2_W-53){a2[A2_W-1]}}, a2, 53'd0};

    bptc_mac #(.A_W(A3_W), .O_W(H2_W)) u_mac_h2 (
        .i_clk (i_clk),
        .i_en  (en),
        .i_a   (a3),
        .i_b   (tn),
        .i_c   (c2),
        .o_y   (h2)
    );

    assign c1 = {{(H1_W-A1_W-85){r_a1_dly[LAT_MAC-1][A1_W-1]}},
                 r_a1_dly[LAT_MAC-1], 85'd0};

    bptc_mac #(.A_W(H2_W), .O_W(H1_W)) u_mac_h1 (
        .i_clk (i_clk),
        .i_en  (en),
        .i_a   (h2),
        .i_b   (r_tn_dly[LAT_MAC-1]),
        .i_c   (c1),
        .o_y   (h1)
    );

    assign c0 = {{(H0_W-A0_W-116){r_a0_dly[NT-1][A0_W-1]}},
                 r_a0_dly[NT-1], 116'd0};

    bptc_mac #(.A_W(H1_W), .O_W(H0_W)) u_mac_h0 (
        .i_clk (i_clk),
        .i_en  (en),
        .i_a   (h1),
        .i_b   (r_tn_dly[NT-1]),
        .i_c   (c0),
        .o_y   (h0)
    );

    // temperature: round half up to 1/256 degC, clamp to 16 bits
    assign t_sum = tn + T_ROUND;
    assign tq    = t_sum[TN_W-1:40];

    always_comb begin
        n_tres.sat  = 1'b0;
        n_tres.temp = tq[15:0];
        if (tq[19:15] != 5'b00000 && tq[19:15] != 5'b11111) begin
            n_tres.sat  = 1'b1;
            n_tres.temp = tq[19] ? 16'sh8000 : 16'sh7fff;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_tn_dly[0]   <= tn;
            r_a0_dly[0]   <= a0;
            r_a1_dly[0]   <= a1;
            r_tres_dly[0] <= n_tres;
            for (int k = 1; k < NT; k++) begin
                r_tn_dly[k] <= r_tn_dly[k-1];
                r_a0_dly[k] <= r_a0_dly[k-1];
            end
            for (int k = 1; k < LAT_MAC; k++) begin
                r_a1_dly[k] <= r_a1_dly[k-1];
            end
            for (int k = 1; k < NR; k++) begin
                r_tres_dly[k] <= r_tres_dly[k-1];
            end
        end
    end

    // pressure: floor of the rounded sum over 2^175, clamp to 24 bits
    assign pq = h0[H0_W-1:P_SHIFT];

    always_comb begin
        n_out.temperature_out = r_tres_dly[NR-1].temp;
        n_out.saturated       = r_tres_dly[NR-1].sat;
        n_out.pressure_out    = pq[23:0];
        if (pq[H0_W-P_SHIFT-1]) begin
            n_out.pressure_out = '0;
            n_out.saturated    = 1'b1;
        end else if (|pq[H0_W-P_SHIFT-2:24]) begin
            n_out.pressure_out = '1;
            n_out.saturated    = 1'b1;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out <= n_out;
        end
    end

    assign o_valid    = r_vld[PIPE_DEPTH-1];
    assign o_out_word = r_out;

    // the pipe comes out of reset empty
    a_empty_after_reset: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !o_valid)
        else $error("output valid right after reset");

    // stall back-pressure only while a word waits at the output
    a_stall_needs_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid)
        else $error("input stalled with no waiting output word");

    // a held output freezes every stage, so no word is lost or doubled
    a_pipe_frozen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> $stable(r_vld))
        else $error("pipe moved while output was held");

endmodule
